FILE: sv/psev_pkg.sv
// Package for the postfix stack evaluator: data width, token codes and controller states.
// It has no dependencies. The top level, the divider and the testbench refer to it by scoped names.
package psev_pkg;

	localparam int DATA_WIDTH = 32;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_OPER = 1'b1;

	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_DIV = 4'd3;
	localparam logic [3:0] OP_NEG = 4'd4;
	localparam logic [3:0] OP_NOT = 4'd5;
	localparam logic [3:0] OP_AND = 4'd6;
	localparam logic [3:0] OP_OR  = 4'd7;
	localparam logic [3:0] OP_EQ  = 4'd8;
	localparam logic [3:0] OP_NE  = 4'd9;
	localparam logic [3:0] OP_LT  = 4'd10;
	localparam logic [3:0] OP_GT  = 4'd11;
	localparam logic [3:0] OP_LE  = 4'd12;
	localparam logic [3:0] OP_GE  = 4'd13;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;

endpackage

FILE: sv/postfix_stack_evaluator_core.sv
// Top level of the postfix stack evaluator: token controller, operator logic and result register.
// It depends on psev_pkg, psev_stack_ram and psev_div.
//
//  channel   | direction | tdata               | tuser                              | tlast
//  s_axis    | in        | [31:0] operand      | [0] action, [4:1] opcode           | end_of_expr
//  m_axis    | out       | [31:0] result       | [0] divide_by_zero, [1] stack_overflow | none
//
// The RAM reads the two top stack entries when a token is accepted; ST_EXEC then computes and
// writes back. A division with a nonzero divisor also waits in ST_DIV for the serial divider.
// Reset clears the stack pointer, the error flags and the result valid flag; the RAM needs no clear.
// A final token waits in its last cycle while the result register is full and not being taken.
module postfix_stack_evaluator_core #(
	parameter int STACK_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] operand
	input  logic [4:0]  s_axis_tuser,  // [0] action, [4:1] opcode
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] result
	output logic [1:0]  m_axis_tuser   // [0] divide_by_zero, [1] stack_overflow
);

	localparam int W   = psev_pkg::DATA_WIDTH;
	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);

	psev_pkg::state_t state_q, state_d;

	logic           tok_action_q;
	logic [3:0]     tok_opcode_q;
	logic [W-1:0]   tok_operand_q;
	logic           tok_last_q;
	logic [SPW-1:0] sp_q;
	logic           err_div_q;
	logic           err_ovf_q;
	logic           out_valid_q;
	logic [W-1:0]   out_result_q;
	logic           out_div_q;
	logic           out_ovf_q;

	logic [W-1:0]   rd_a_s1;
	logic [W-1:0]   rd_b_s1;
	logic           accept;
	logic [SPW-1:0] sp_m1;
	logic [SPW-1:0] sp_m2;

	logic [W-1:0]   val_a;
	logic [W-1:0]   val_b;
	logic [SPW-1:0] sp_pop1;
	logic [SPW-1:0] sp_pop2;
	logic [W-1:0]   prod;
	logic [W-1:0]   quot;
	logic           lt_ab;
	logic           lt_ba;

	logic           plan_wr;
	logic [SPW-1:0] plan_wr_sp;
	logic [W-1:0]   plan_val;
	logic [W-1:0]   plan_top;
	logic [SPW-1:0] plan_sp;
	logic           plan_set_div;
	logic           plan_set_ovf;
	logic           plan_needs_div;

	logic           blocked;
	logic           commit;
	logic           div_start;
	psev_pkg::div_ctl_t div_ctl;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign sp_m1  = sp_q - SPW'(1);
	assign sp_m2  = sp_q - SPW'(2);

	psev_stack_ram #(
		.DEPTH (STACK_DEPTH),
		.WIDTH (W),
		.AW    (AW)
	) u_ram (
		.clk       (clk),
		.wr_en     (commit && plan_wr && !tok_last_q),
		.wr_addr   (plan_wr_sp[AW-1:0]),
		.wr_data   (plan_val),
		.rd_en     (accept),
		.rd_addr_a (sp_m1[AW-1:0]),
		.rd_addr_b (sp_m2[AW-1:0]),
		.rd_data_a (rd_a_s1),
		.rd_data_b (rd_b_s1)
	);

	assign val_b   = (sp_q != '0) ? rd_a_s1 : '0;
	assign val_a   = (sp_q >= SPW'(2)) ? rd_b_s1 : '0;
	assign sp_pop1 = (sp_q != '0) ? sp_m1 : '0;
	assign sp_pop2 = (sp_q >= SPW'(2)) ? sp_m2 : '0;
	assign prod    = val_a * val_b;
	assign lt_ab   = $signed(val_a) < $signed(val_b);
	assign lt_ba   = $signed(val_b) < $signed(val_a);

	psev_div #(
		.W (W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (val_a),
		.divisor  (val_b),
		.ctl      (div_ctl),
		.quotient (quot)
	);

	always_comb begin
		plan_wr        = 1'b1;
		plan_wr_sp     = sp_pop2;
		plan_val       = '0;
		plan_set_div   = 1'b0;
		plan_set_ovf   = 1'b0;
		plan_needs_div = 1'b0;
		if (tok_action_q == psev_pkg::ACT_PUSH) begin
			plan_wr_sp = sp_q;
			plan_val   = tok_operand_q;
			if (sp_q >= SPW'(STACK_DEPTH)) begin
				plan_wr      = 1'b0;
				plan_set_ovf = 1'b1;
			end
		end else begin
			case (tok_opcode_q)
				psev_pkg::OP_ADD: plan_val = val_a + val_b;
				psev_pkg::OP_SUB: plan_val = val_a - val_b;
				psev_pkg::OP_MUL: plan_val = prod;
				psev_pkg::OP_DIV: begin
					if (val_b == '0) begin
						plan_set_div = 1'b1;
					end else begin
						plan_val       = quot;
						plan_needs_div = 1'b1;
					end
				end
				psev_pkg::OP_NEG: begin
					plan_wr_sp = sp_pop1;
					plan_val   = '0 - val_b;
				end
				psev_pkg::OP_NOT: begin
					plan_wr_sp = sp_pop1;
					plan_val   = W'(val_b == '0);
				end
				psev_pkg::OP_AND: plan_val = W'((val_a != '0) && (val_b != '0));
				psev_pkg::OP_OR:  plan_val = W'((val_a != '0) || (val_b != '0));
				psev_pkg::OP_EQ:  plan_val = W'(val_a == val_b);
				psev_pkg::OP_NE:  plan_val = W'(val_a != val_b);
				psev_pkg::OP_LT:  plan_val = W'(lt_ab);
				psev_pkg::OP_GT:  plan_val = W'(lt_ba);
				psev_pkg::OP_LE:  plan_val = W'(!lt_ba);
				psev_pkg::OP_GE:  plan_val = W'(!lt_ab);
				default: begin
					plan_wr = 1'b0;
				end
			endcase
		end
		plan_sp  = plan_wr ? (plan_wr_sp + SPW'(1)) : sp_q;
		plan_top = plan_wr ? plan_val : val_b;
	end

	assign blocked = tok_last_q && out_valid_q && !m_axis_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			psev_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = psev_pkg::ST_EXEC;
				end
			end
			psev_pkg::ST_EXEC: begin
				if (plan_needs_div) begin
					state_d = psev_pkg::ST_DIV;
				end else if (!blocked) begin
					state_d = psev_pkg::ST_IDLE;
				end
			end
			psev_pkg::ST_DIV: begin
				if (!div_ctl.busy && !blocked) begin
					state_d = psev_pkg::ST_IDLE;
				end
			end
			default: state_d = psev_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		commit        = 1'b0;
		case (state_q)
			psev_pkg::ST_IDLE: s_axis_tready = 1'b1;
			psev_pkg::ST_EXEC: begin
				div_start = plan_needs_div;
				commit    = !plan_needs_div && !blocked;
			end
			psev_pkg::ST_DIV: commit = !div_ctl.busy && !blocked;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psev_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_action_q  <= s_axis_tuser[0];
			tok_opcode_q  <= s_axis_tuser[4:1];
			tok_operand_q <= s_axis_tdata;
			tok_last_q    <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q      <= '0;
			err_div_q <= 1'b0;
			err_ovf_q <= 1'b0;
		end else if (commit) begin
			if (tok_last_q) begin
				sp_q      <= '0;
				err_div_q <= 1'b0;
				err_ovf_q <= 1'b0;
			end else begin
				sp_q      <= plan_sp;
				err_div_q <= err_div_q || plan_set_div;
				err_ovf_q <= err_ovf_q || plan_set_ovf;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit && tok_last_q) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && tok_last_q) begin
			out_result_q <= plan_top;
			out_div_q    <= err_div_q || plan_set_div;
			out_ovf_q    <= err_ovf_q || plan_set_ovf;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_result_q;
	assign m_axis_tuser  = {out_ovf_q, out_div_q};

	property p_sp_bound;
		@(posedge clk) disable iff (!arst_n) sp_q <= SPW'(STACK_DEPTH);
	endproperty
	a_sp_bound: assert property (p_sp_bound) else $error("stack pointer beyond depth");

	property p_last_clears;
		@(posedge clk) disable iff (!arst_n)
			commit && tok_last_q |=> (sp_q == '0) && !err_div_q && !err_ovf_q && out_valid_q;
	endproperty
	a_last_clears: assert property (p_last_clears) else $error("final token did not clear state");

	property p_div_state;
		@(posedge clk) disable iff (!arst_n) div_ctl.busy |-> (state_q == psev_pkg::ST_DIV);
	endproperty
	a_div_state: assert property (p_div_state) else $error("divider busy outside divide wait");

	property p_no_overwrite;
		@(posedge clk) disable iff (!arst_n)
			commit && tok_last_q |-> !out_valid_q || m_axis_tready;
	endproperty
	a_no_overwrite: assert property (p_no_overwrite) else $error("pending result overwritten");

endmodule

FILE: sv/psev_stack_ram.sv
// Operand stack storage: one synchronous write port and two registered read ports.
// It depends on no package; the top level sets depth and width.
module psev_stack_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr_a,
	input  logic [AW-1:0]    rd_addr_b,
	output logic [WIDTH-1:0] rd_data_a,
	output logic [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

FILE: sv/psev_div.sv
// Sequential signed divider, one quotient bit per cycle, truncating toward zero.
// It depends on psev_pkg for the control struct; the divisor must be nonzero.
module psev_div #(
	parameter int W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [W-1:0]      dividend,
	input  logic [W-1:0]      divisor,
	output psev_pkg::div_ctl_t ctl,
	output logic [W-1:0]      quotient
);

	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dsr_q;
	logic          neg_q;
	logic [W:0]    shifted;
	logic [W:0]    trial;
	logic          ge;

	assign shifted = {rem_q, quo_q[W-1]};
	assign trial   = shifted - {1'b0, dsr_q};
	assign ge      = !trial[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[W-1] ? (~dividend + W'(1)) : dividend;
			dsr_q <= divisor[W-1] ? (~divisor + W'(1)) : divisor;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (busy_q) begin
			rem_q <= ge ? trial[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign quotient  = neg_q ? (~quo_q + W'(1)) : quo_q;

	property p_count_live;
		@(posedge clk) disable iff (!arst_n) busy_q |-> (cnt_q != '0);
	endproperty
	a_count_live: assert property (p_count_live) else $error("divider busy with zero count");

	property p_start_loads;
		@(posedge clk) disable iff (!arst_n) start |=> busy_q && (cnt_q == CW'(W));
	endproperty
	a_start_loads: assert property (p_start_loads) else $error("divider start not taken");

	property p_no_restart;
		@(posedge clk) disable iff (!arst_n) busy_q |-> !start;
	endproperty
	a_no_restart: assert property (p_no_restart) else $error("divider restarted while busy");

endmodule

FILE: bench/tb.sv
// Self-checking testbench for postfix_stack_evaluator_core: random and directed RPN token streams.
// A scoreboard class predicts each final result and matches it against the m_axis transfers.
// It depends on psev_pkg and the postfix_stack_evaluator_core RTL.
module tb;

	localparam int STACK_DEPTH = 256;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DATA_WIDTH  = psev_pkg::DATA_WIDTH;

	typedef struct {
		logic [DATA_WIDTH-1:0] value;
		logic                  div_zero;
		logic                  overflow;
	} expr_result_t;

	class rpn_result_tracker;
		logic [DATA_WIDTH-1:0] stack_mem [STACK_DEPTH];
		int unsigned           depth;
		bit                    div_zero_seen;
		bit                    overflow_seen;
		expr_result_t          pending_results [$];
		int                    failures;

		function new();
			depth = 0;
			div_zero_seen = 0;
			overflow_seen = 0;
			failures = 0;
		endfunction

		function logic [DATA_WIDTH-1:0] pop_entry();
			if (depth == 0) begin
				return '0;
			end
			depth--;
			return stack_mem[depth];
		endfunction

		function void push_entry(logic [DATA_WIDTH-1:0] v);
			if (depth >= STACK_DEPTH) begin
				overflow_seen = 1;
			end else begin
				stack_mem[depth] = v;
				depth++;
			end
		endfunction

		function void note_token(logic action, logic [3:0] opcode, logic [DATA_WIDTH-1:0] operand,
				logic last);
			logic [DATA_WIDTH-1:0] a;
			logic [DATA_WIDTH-1:0] b;
			logic [DATA_WIDTH-1:0] r;
			longint                quotient;
			expr_result_t          res;
			if (action == psev_pkg::ACT_PUSH) begin
				push_entry(operand);
			end else if (opcode == psev_pkg::OP_NEG) begin
				a = pop_entry();
				push_entry(-a);
			end else if (opcode == psev_pkg::OP_NOT) begin
				a = pop_entry();
				push_entry((a == 0) ? 1 : 0);
			end else if (opcode <= psev_pkg::OP_GE) begin
				b = pop_entry();
				a = pop_entry();
				case (opcode)
					psev_pkg::OP_ADD: r = a + b;
					psev_pkg::OP_SUB: r = a - b;
					psev_pkg::OP_MUL: r = a * b;
					psev_pkg::OP_DIV: begin
						if (b == 0) begin
							div_zero_seen = 1;
							r = '0;
						end else begin
							quotient = longint'($signed(a)) / longint'($signed(b));
							r = quotient[DATA_WIDTH-1:0];
						end
					end
					psev_pkg::OP_AND: r = (a != 0 && b != 0) ? 1 : 0;
					psev_pkg::OP_OR:  r = (a != 0 || b != 0) ? 1 : 0;
					psev_pkg::OP_EQ:  r = (a == b) ? 1 : 0;
					psev_pkg::OP_NE:  r = (a != b) ? 1 : 0;
					psev_pkg::OP_LT:  r = ($signed(a) < $signed(b)) ? 1 : 0;
					psev_pkg::OP_GT:  r = ($signed(a) > $signed(b)) ? 1 : 0;
					psev_pkg::OP_LE:  r = ($signed(a) <= $signed(b)) ? 1 : 0;
					default: r = ($signed(a) >= $signed(b)) ? 1 : 0;
				endcase
				push_entry(r);
			end
			if (last) begin
				res.value = (depth == 0) ? '0 : stack_mem[depth-1];
				res.div_zero = div_zero_seen;
				res.overflow = overflow_seen;
				pending_results.push_back(res);
				depth = 0;
				div_zero_seen = 0;
				overflow_seen = 0;
			end
		endfunction

		function void check_result(logic [DATA_WIDTH-1:0] value, logic div_zero, logic overflow);
			expr_result_t exp_res;
			if (pending_results.size() == 0) begin
				$error("unexpected result transfer: result %h", value);
				failures++;
				return;
			end
			exp_res = pending_results.pop_front();
			if (value !== exp_res.value) begin
				$error("result: expected %h, actual %h", exp_res.value, value);
				failures++;
			end
			if (div_zero !== exp_res.div_zero) begin
				$error("divide_by_zero: expected %b, actual %b", exp_res.div_zero, div_zero);
				failures++;
			end
			if (overflow !== exp_res.overflow) begin
				$error("stack_overflow: expected %b, actual %b", exp_res.overflow, overflow);
				failures++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [4:0]  s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	rpn_result_tracker tracker;
	bit                idle_on;
	int                tokens_sent;
	int                stall_left;
	int                cycle_count;

	postfix_stack_evaluator_core #(
		.STACK_DEPTH(STACK_DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin
		if (stall_left != 0) begin
			m_axis_tready = 0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			m_axis_tready = 0;
			stall_left = $urandom_range(0, 4);
		end else begin
			m_axis_tready = 1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("postfix_stack_evaluator_core verification failed");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			tracker.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
		end
	end

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 32'($urandom_range(0, 6)) - 32'd3;
			4: begin
				case ($urandom_range(0, 4))
					0: return 32'h0000_0000;
					1: return 32'h0000_0001;
					2: return 32'hffff_ffff;
					3: return 32'h8000_0000;
					default: return 32'h7fff_ffff;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Called and returning at a falling edge; the token stays driven until its transfer.
	task automatic send_token(logic action, logic [3:0] opcode, logic [31:0] operand, logic last);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid = 0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_axis_tvalid = 1;
		s_axis_tdata = operand;
		s_axis_tuser = {opcode, action};
		s_axis_tlast = last;
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_token(action, opcode, operand, last);
		tokens_sent++;
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		s_axis_tvalid = 0;
		do @(negedge clk); while (tracker.pending_results.size() != 0);
	endtask

	// Mostly well-formed expressions with a share of malformed tokens mixed in.
	task automatic send_random_expr();
		int         len;
		int         depth;
		logic [3:0] op;
		bit         last;
		len = $urandom_range(1, 14);
		depth = 0;
		for (int i = 0; i < len; i++) begin
			last = (i == len - 1);
			if ($urandom_range(0, 9) == 0) begin
				send_token(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), $urandom, last);
			end else if (depth == 0 || $urandom_range(0, 2) == 0) begin
				send_token(psev_pkg::ACT_PUSH, 4'($urandom), pick_operand(), last);
				depth++;
			end else if (depth == 1) begin
				op = ($urandom_range(0, 1) == 0) ? psev_pkg::OP_NEG : psev_pkg::OP_NOT;
				send_token(psev_pkg::ACT_OPER, op, $urandom, last);
			end else begin
				op = 4'($urandom_range(psev_pkg::OP_ADD, psev_pkg::OP_GE));
				send_token(psev_pkg::ACT_OPER, op, $urandom, last);
				if (op != psev_pkg::OP_NEG && op != psev_pkg::OP_NOT) begin
					depth--;
				end
			end
		end
	endtask

	// Fills the stack past its capacity, then optionally folds it with binary operators.
	task automatic fill_stack_expr(int extra, int ops_after);
		int         pushes;
		logic [3:0] op;
		pushes = STACK_DEPTH + extra;
		for (int i = 0; i < pushes; i++) begin
			send_token(psev_pkg::ACT_PUSH, 4'($urandom), pick_operand(),
				ops_after == 0 && i == pushes - 1);
		end
		for (int i = 0; i < ops_after; i++) begin
			do op = 4'($urandom_range(psev_pkg::OP_ADD, psev_pkg::OP_GE));
			while (op == psev_pkg::OP_NEG || op == psev_pkg::OP_NOT);
			send_token(psev_pkg::ACT_OPER, op, $urandom, i == ops_after - 1);
		end
	endtask

	initial begin
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		s_axis_tlast = 0;
		m_axis_tready = 1;
		stall_left = 0;
		cycle_count = 0;
		tokens_sent = 0;
		idle_on = 1;
		tracker = new();
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Operators on an empty stack and an unused opcode as the only token.
		send_token(psev_pkg::ACT_OPER, psev_pkg::OP_ADD, 32'h0, 1);
		send_token(psev_pkg::ACT_OPER, 4'd15, 32'hffff_ffff, 1);

		// Wrapping add, most negative divided by -1, divide by zero, not and negate.
		send_token(psev_pkg::ACT_PUSH, psev_pkg::OP_GE, 32'h7fff_ffff, 0);
		send_token(psev_pkg::ACT_PUSH, 4'd0, 32'h0000_0001, 0);
		send_token(psev_pkg::ACT_OPER, psev_pkg::OP_ADD, 32'h0, 0);
		send_token(psev_pkg::ACT_PUSH, 4'd15, 32'hffff_ffff, 0);
		send_token(psev_pkg::ACT_OPER, psev_pkg::OP_DIV, 32'h0, 0);
		send_token(psev_pkg::ACT_PUSH, 4'd0, 32'h0, 0);
		send_token(psev_pkg::ACT_OPER, psev_pkg::OP_DIV, 32'hffff_ffff, 0);
		send_token(psev_pkg::ACT_OPER, psev_pkg::OP_NOT, 32'h0, 0);
		send_token(psev_pkg::ACT_OPER, psev_pkg::OP_NEG, 32'h0, 1);

		// Truncating division, a multiply and the LE, EQ and LT compares, ending on an unused opcode.
		send_token(psev_pkg::ACT_PUSH, 4'd0, 32'hffff_fff9, 0);
		send_token(psev_pkg::ACT_PUSH, 4'd0, 32'h0000_0002, 0);
		send_token(psev_pkg::ACT_OPER, psev_pkg::OP_DIV, 32'h0, 0);
		send_token(psev_pkg::ACT_PUSH, 4'd0, 32'h0000_0004, 0);
		send_token(psev_pkg::ACT_OPER, psev_pkg::OP_LE, 32'h0, 0);
		send_token(psev_pkg::ACT_PUSH, 4'd0, 32'h0000_0001, 0);
		send_token(psev_pkg::ACT_OPER, psev_pkg::OP_EQ, 32'h0, 0);
		send_token(psev_pkg::ACT_PUSH, 4'd0, 32'h8000_0000, 0);
		send_token(psev_pkg::ACT_OPER, psev_pkg::OP_MUL, 32'h0, 0);
		send_token(psev_pkg::ACT_PUSH, 4'd0, 32'h0, 0);
		send_token(psev_pkg::ACT_OPER, psev_pkg::OP_LT, 32'h0, 0);
		send_token(psev_pkg::ACT_OPER, 4'd14, 32'h0, 1);

		while (tokens_sent < 620) send_random_expr();
		wait_for_results();
		fill_stack_expr(3, 0);
		while (tokens_sent < 1160) send_random_expr();
		wait_for_results();
		fill_stack_expr(1, 6);
		while (tokens_sent < 1500) send_random_expr();
		idle_on = 0;
		while (tokens_sent < 1650) send_random_expr();

		wait_for_results();
		repeat (60) @(negedge clk);
		if (tracker.pending_results.size() != 0) begin
			$error("%0d expected results never arrived", tracker.pending_results.size());
			tracker.failures++;
		end
		if (tracker.failures == 0) begin
			$display("postfix_stack_evaluator_core verification clean");
		end else begin
			$display("postfix_stack_evaluator_core verification failed");
		end
		$finish;
	end

endmodule
